FILE: sv/bht_pkg.sv
// ----------------------------------------------------------------------------
// bht_pkg
// Shared types and constants of the bucketed hash table.
// ----------------------------------------------------------------------------
package bht_pkg;

	localparam int KEY_W = 64;
	localparam int VAL_W = 64;
	localparam int CNT_W = 11;
	localparam int CMD_W = 2;
	localparam int STS_W = 2;

	// Written into both key and value of the slot that a remove frees.
	localparam logic [KEY_W-1:0] FILL_PATTERN = 64'h5555_5555_5555_5555;

	typedef enum logic [CMD_W-1:0] {
		CMD_LOOKUP = 2'd0,
		CMD_INSERT = 2'd1,
		CMD_REMOVE = 2'd2
	} cmd_t;

	typedef enum logic [STS_W-1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2,
		ST_DUP       = 2'd3
	} status_t;

endpackage

FILE: sv/bucketed_hash_table.sv
// ----------------------------------------------------------------------------
// bucketed_hash_table
// Hash table of 64-bit keys and values, one row of slots per bucket held in
// a single synchronous memory with read, compare and write-back per item.
// ----------------------------------------------------------------------------
//  Channel  Signals                               Direction  Transfer
//  in       in_valid in_ready cmd key value       to block   valid & ready
//  out      out_valid out_ready status            from block valid & ready
//           found_value entry_count
//
// Each item is read, compared and written back: the bucket row is read at the
// transfer, the slot keys are compared in the next cycle, and the row is
// written back and the result registered in S_WR once the output register is
// free. After reset a clearing pass zeroes the fill count of every row, with
// in_ready low. A finished result waits in the output register; a new item
// is taken meanwhile, and it stalls at write-back until that register is free.
// ----------------------------------------------------------------------------
module bucketed_hash_table #(
	parameter int BUCKETS = 256,
	parameter int SLOTS   = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [bht_pkg::CMD_W-1:0]     cmd,
	input  logic [bht_pkg::KEY_W-1:0]     key,
	input  logic [bht_pkg::VAL_W-1:0]     value,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [bht_pkg::STS_W-1:0]     status,
	output logic [bht_pkg::VAL_W-1:0]     found_value,
	output logic [bht_pkg::CNT_W-1:0]     entry_count
);

	localparam int BW    = $clog2(BUCKETS);
	localparam int FW    = $clog2(SLOTS);
	localparam int KW    = SLOTS * bht_pkg::KEY_W;
	localparam int VW    = SLOTS * bht_pkg::VAL_W;
	localparam int ROW_W = FW + KW + VW;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_CMP,
		S_WR
	} state_t;

	state_t state_q;
	logic [BW-1:0] clr_q;
	logic [bht_pkg::CNT_W-1:0] total_q;
	logic out_valid_q;
	logic [bht_pkg::STS_W-1:0] status_q;
	logic [bht_pkg::VAL_W-1:0] found_q;

	// Item registers.
	logic [bht_pkg::CMD_W-1:0] cmd_q;
	logic [bht_pkg::KEY_W-1:0] key_q;
	logic [bht_pkg::VAL_W-1:0] val_q;
	logic [BW-1:0] bkt_q;

	// Row memory.
	logic [ROW_W-1:0] mem [BUCKETS];
	logic [ROW_W-1:0] row_s1;
	logic [BW-1:0] rd_addr;
	logic rd_en;
	logic wr_en;
	logic [BW-1:0] wr_addr;
	logic [ROW_W-1:0] wr_row;

	logic [SLOTS-1:0][bht_pkg::KEY_W-1:0] keys;
	logic [SLOTS-1:0][bht_pkg::VAL_W-1:0] vals;
	logic [FW-1:0] fill;
	logic hit;
	logic [FW-1:0] pos;
	logic hit_s2;
	logic [FW-1:0] pos_s2;

	logic [SLOTS-1:0][bht_pkg::KEY_W-1:0] up_keys;
	logic [SLOTS-1:0][bht_pkg::VAL_W-1:0] up_vals;
	logic [SLOTS-1:0][bht_pkg::KEY_W-1:0] new_keys;
	logic [SLOTS-1:0][bht_pkg::VAL_W-1:0] new_vals;
	logic [FW-1:0] new_fill;
	logic do_write;
	logic [bht_pkg::STS_W-1:0] new_status;
	logic [bht_pkg::VAL_W-1:0] new_found;
	logic [bht_pkg::CNT_W-1:0] new_total;
	logic out_free;
	logic wr_done;

	assign in_ready    = (state_q == S_IDLE);
	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign found_value = found_q;
	assign entry_count = total_q;

	assign rd_en   = in_valid && in_ready;
	assign rd_addr = key[BW-1:0] & BW'(BUCKETS - 1);

	assign out_free = !out_valid_q || out_ready;
	assign wr_done  = (state_q == S_WR) && out_free;

	always_comb begin
		for (int i = 0; i < SLOTS; i++) begin
			keys[i] = row_s1[i*bht_pkg::KEY_W +: bht_pkg::KEY_W];
			vals[i] = row_s1[KW + i*bht_pkg::VAL_W +: bht_pkg::VAL_W];
		end
		fill = row_s1[KW + VW +: FW];
	end

	bht_match #(
		.SLOTS(SLOTS),
		.FW   (FW)
	) u_match (
		.keys(keys),
		.fill(fill),
		.key (key_q),
		.hit (hit),
		.pos (pos)
	);

	// Entries moved down by one slot, for the remove path.
	always_comb begin
		for (int j = 0; j < SLOTS - 1; j++) begin
			up_keys[j] = keys[j+1];
			up_vals[j] = vals[j+1];
		end
		up_keys[SLOTS-1] = bht_pkg::FILL_PATTERN;
		up_vals[SLOTS-1] = bht_pkg::FILL_PATTERN;
	end

	always_comb begin
		new_keys   = keys;
		new_vals   = vals;
		new_fill   = fill;
		do_write   = 1'b0;
		new_status = bht_pkg::ST_NOT_FOUND;
		new_found  = '0;
		new_total  = total_q;
		case (bht_pkg::cmd_t'(cmd_q))
			bht_pkg::CMD_LOOKUP: begin
				if (hit_s2) begin
					new_status = bht_pkg::ST_OK;
					new_found  = vals[pos_s2];
				end
			end
			bht_pkg::CMD_INSERT: begin
				if (hit_s2) begin
					new_status = bht_pkg::ST_DUP;
				end else if (fill == FW'(SLOTS - 1)) begin
					new_status = bht_pkg::ST_FULL;
				end else begin
					new_keys[fill] = key_q;
					new_vals[fill] = val_q;
					new_fill       = fill + 1'b1;
					new_total      = total_q + 1'b1;
					do_write       = 1'b1;
					new_status     = bht_pkg::ST_OK;
				end
			end
			bht_pkg::CMD_REMOVE: begin
				if (hit_s2) begin
					new_found = vals[pos_s2];
					for (int j = 0; j < SLOTS; j++) begin
						if (FW'(j) >= pos_s2) begin
							if ((FW+1)'(j + 1) < {1'b0, fill}) begin
								new_keys[j] = up_keys[j];
								new_vals[j] = up_vals[j];
							end else if ((FW+1)'(j + 1) == {1'b0, fill}) begin
								new_keys[j] = bht_pkg::FILL_PATTERN;
								new_vals[j] = bht_pkg::FILL_PATTERN;
							end
						end
					end
					new_fill   = fill - 1'b1;
					new_total  = total_q - 1'b1;
					do_write   = 1'b1;
					new_status = bht_pkg::ST_OK;
				end
			end
			default: begin
				new_status = bht_pkg::ST_NOT_FOUND;
			end
		endcase
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = bkt_q;
		wr_row  = {new_fill, new_vals, new_keys};
		if (state_q == S_CLEAR) begin
			wr_en   = 1'b1;
			wr_addr = clr_q;
			wr_row  = '0;
		end else if (wr_done && do_write) begin
			wr_en = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_row;
		end
		if (rd_en) begin
			row_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			cmd_q <= cmd;
			key_q <= key;
			val_q <= value;
			bkt_q <= rd_addr;
		end
		if (state_q == S_CMP) begin
			hit_s2 <= hit;
			pos_s2 <= pos;
		end
		if (wr_done) begin
			status_q <= new_status;
			found_q  <= new_found;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == BW'(BUCKETS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					state_q <= S_WR;
				end
				S_WR: begin
					if (out_free) begin
						total_q     <= new_total;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: sv/bht_match.sv
// ----------------------------------------------------------------------------
// bht_match
// Compares a key against the occupied slots of one bucket row and returns
// the position of the first match.
// ----------------------------------------------------------------------------
module bht_match #(
	parameter int SLOTS = 8,
	parameter int FW    = 3
) (
	input  logic [SLOTS-1:0][bht_pkg::KEY_W-1:0] keys,
	input  logic [FW-1:0]                        fill,
	input  logic [bht_pkg::KEY_W-1:0]            key,
	output logic                                 hit,
	output logic [FW-1:0]                        pos
);

	logic [SLOTS-1:0] match;

	always_comb begin
		for (int i = 0; i < SLOTS; i++) begin
			match[i] = (keys[i] == key) && (FW'(i) < fill);
		end
	end

	// Scan from the top so that the lowest matching slot wins.
	always_comb begin
		hit = 1'b0;
		pos = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (match[i]) begin
				hit = 1'b1;
				pos = FW'(i);
			end
		end
	end

endmodule

FILE: sv/bht_checker.sv
// ----------------------------------------------------------------------------
// bht_checker
// Port-level checks of the bucketed hash table, bound to the top level.
// ----------------------------------------------------------------------------
module bht_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_ready,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic [bht_pkg::STS_W-1:0] status,
	input logic [bht_pkg::VAL_W-1:0] found_value,
	input logic [bht_pkg::CNT_W-1:0] entry_count
);

	// A stalled result holds its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) &&
			$stable(found_value) && $stable(entry_count))
		else $error("result changed while stalled");

	// Only a successful lookup or remove returns a value.
	a_found_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != bht_pkg::ST_OK |-> found_value == '0)
		else $error("nonzero value with a failing status");

	// One item at a time: the cycle after an input transfer takes nothing.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while an item is in flight");

	// A result never appears in the cycle right after an input transfer.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !out_valid |=> !out_valid)
		else $error("result came too early");

endmodule

bind bucketed_hash_table bht_checker u_bht_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.status     (status),
	.found_value(found_value),
	.entry_count(entry_count)
);
